/* design/sccs_tag_stream_extractor_assert.svh */
// Assertion macros for the SCCS tag stream extractor.
// Used by the top level only; needs no package.
`ifndef SCCS_TAG_STREAM_EXTRACTOR_ASSERT_SVH
`define SCCS_TAG_STREAM_EXTRACTOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SCCS_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sccs assertion failed");

// Next-cycle implication, disabled during reset.
`define SCCS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sccs assertion failed");

`endif

/* design/sccs_pkg.sv */
// Shared types, character codes and helpers for the SCCS tag stream extractor.
// No dependencies.
`default_nettype none

package sccs_pkg;

  localparam int NAME_MAX_DEF    = 32;
  localparam int OFFSET_BITS_DEF = 24;
  localparam int CFG_INDEX_W     = 1;
  localparam int PAD_COLS        = 14;

  localparam logic [CFG_INDEX_W-1:0] CFG_STRIP_DIRS  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SHOW_OFFSET = 1'd1;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] NAME_LO   = 8'h21;
  localparam logic [7:0] NAME_HI   = 8'h7F;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       run_last;
  } out_item_t;

  typedef enum logic [2:0] {
    SEL_SPACE,
    SEL_HEX,
    SEL_NAME,
    SEL_REST,
    SEL_NEWLINE
  } char_sel_t;

  // Work that one accepted byte calls for, in emission order.
  typedef struct packed {
    logic hdr;
    logic flush;
    logic chr;
    logic nl;
  } plan_t;

  typedef struct packed {
    logic      accept;
    logic      emit;
    char_sel_t sel;
    logic      last;
    logic [2:0] hex_idx;
    logic      name_start;
    logic      name_rd;
    logic      name_step;
    logic      clear_name;
  } ctrl_cmd_t;

  typedef struct packed {
    plan_t      plan;
    logic       show_offset;
    logic [2:0] ndig_m1;
    logic [3:0] pad_len;
    logic       name_nonempty;
    logic       name_tail;
    logic       out_free;
  } ctrl_status_t;

  function automatic logic [7:0] mark_char(input logic [1:0] stage);
    logic [7:0] c;
    case (stage)
      2'd0:    c = CH_AT;
      2'd1:    c = CH_LPAREN;
      2'd2:    c = CH_HASH;
      default: c = CH_RPAREN;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) c = 8'h30 + {4'd0, nib};
    else c = 8'h57 + {4'd0, nib};
    return c;
  endfunction

  function automatic logic is_sep(input logic [7:0] c);
    return (c == CH_SLASH) || (c == CH_BSLASH);
  endfunction

endpackage

`default_nettype wire

/* design/sccs_datapath.sv */
// Datapath of the SCCS tag stream extractor: scan state, name store,
// offset counter, character mux and output register. Uses sccs_pkg.
`default_nettype none

module sccs_datapath import sccs_pkg::*; #(
  parameter int NAME_MAX    = NAME_MAX_DEF,
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire in_item_t               in_data,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic                   cfg_data,
  input  wire ctrl_cmd_t              cmd,
  output ctrl_status_t                st,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output out_item_t                   out_data
);

  localparam int FILL_W = $clog2(NAME_MAX + 1);
  localparam int IDX_W  = $clog2(NAME_MAX);

  typedef enum logic [1:0] {PH_SEARCH, PH_NAME, PH_REST} phase_t;

  logic                   strip_dirs;
  logic                   show_offset;
  phase_t                 phase;
  logic [1:0]             match;
  logic [FILL_W-1:0]      fill;
  logic [FILL_W-1:0]      name_from;
  logic [3:0]             base_len;
  logic [OFFSET_BITS-1:0] byte_offset;
  logic [OFFSET_BITS-1:0] hex_val;
  logic [7:0]             rest_byte;
  logic [FILL_W-1:0]      rd_idx;
  logic [7:0]             rd_data;
  logic [7:0]             store [NAME_MAX];

  logic [7:0]  b;
  logic        eof;
  logic        is_name;
  logic        do_store;
  phase_t      phase_next;
  logic [1:0]  match_next;
  plan_t       plan;
  logic [31:0] hex32;
  logic [FILL_W-1:0] from_sel;
  logic [7:0]  ch;

  assign b       = in_data.data_byte;
  assign eof     = in_data.end_of_file;
  assign is_name = (b >= NAME_LO) && (b <= NAME_HI);

  always_comb begin
    phase_next = phase;
    match_next = match;
    plan       = '0;
    do_store   = 1'b0;
    case (phase)
      PH_NAME: begin
        if (is_name) begin
          do_store = (fill < FILL_W'(NAME_MAX));
        end else begin
          plan.flush = 1'b1;
          if (b == CH_NUL) begin
            plan.nl    = 1'b1;
            phase_next = PH_SEARCH;
          end else begin
            phase_next = PH_REST;
          end
        end
      end
      PH_REST: begin
        if (b == CH_NUL || b == CH_CR || b == CH_LF) begin
          plan.nl    = 1'b1;
          phase_next = PH_SEARCH;
        end else begin
          plan.chr = 1'b1;
        end
      end
      default: begin
        if (b == mark_char(match)) begin
          if (match == 2'd3) begin
            plan.hdr   = 1'b1;
            phase_next = PH_NAME;
            match_next = 2'd0;
          end else begin
            match_next = match + 2'd1;
          end
        end else begin
          match_next = (b == CH_AT) ? 2'd1 : 2'd0;
        end
      end
    endcase
    // end of file closes an open name or rest as a NUL would
    if (eof) begin
      if (phase_next == PH_NAME) begin
        plan.flush = 1'b1;
        plan.nl    = 1'b1;
      end else if (phase_next == PH_REST) begin
        plan.nl = 1'b1;
      end
      phase_next = PH_SEARCH;
      match_next = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strip_dirs  <= 1'b0;
      show_offset <= 1'b0;
      phase       <= PH_SEARCH;
      match       <= 2'd0;
      fill        <= '0;
      name_from   <= '0;
      base_len    <= 4'd0;
      byte_offset <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_STRIP_DIRS:  strip_dirs  <= cfg_data;
          CFG_SHOW_OFFSET: show_offset <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.accept) begin
        phase       <= phase_next;
        match       <= match_next;
        byte_offset <= eof ? '0 : byte_offset + OFFSET_BITS'(1);
        if (do_store) begin
          fill <= fill + FILL_W'(1);
          if (is_sep(b)) begin
            base_len  <= 4'd0;
            name_from <= fill + FILL_W'(1);
          end else if (base_len != 4'd15) begin
            base_len <= base_len + 4'd1;
          end
        end
      end
      if (cmd.clear_name) begin
        fill      <= '0;
        name_from <= '0;
        base_len  <= 4'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      hex_val   <= byte_offset + OFFSET_BITS'(1);
      rest_byte <= b;
    end
    if (cmd.accept && do_store) begin
      store[fill[IDX_W-1:0]] <= b;
    end
    if (cmd.name_rd) begin
      rd_data <= store[rd_idx[IDX_W-1:0]];
    end
    if (cmd.name_start) begin
      rd_idx <= from_sel;
    end else if (cmd.name_step) begin
      rd_idx <= rd_idx + FILL_W'(1);
    end
  end

  assign hex32    = 32'(hex_val);
  assign from_sel = strip_dirs ? name_from : '0;

  always_comb begin
    st.plan          = plan;
    st.show_offset   = show_offset;
    if (hex32[31:28] != 4'd0)      st.ndig_m1 = 3'd7;
    else if (hex32[27:24] != 4'd0) st.ndig_m1 = 3'd6;
    else                           st.ndig_m1 = 3'd5;
    st.pad_len       = (base_len >= 4'd13) ? 4'd1 : 4'(PAD_COLS) - base_len;
    st.name_nonempty = (from_sel < fill);
    st.name_tail     = ((rd_idx + FILL_W'(1)) >= fill);
    st.out_free      = !out_valid || out_ready;
  end

  always_comb begin
    case (cmd.sel)
      SEL_HEX:     ch = hex_char(hex32[{cmd.hex_idx, 2'b00} +: 4]);
      SEL_NAME:    ch = rd_data;
      SEL_REST:    ch = rest_byte;
      SEL_NEWLINE: ch = CH_LF;
      default:     ch = CH_SPACE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data.out_char <= ch;
      out_data.run_last <= cmd.last;
    end
  end

endmodule

`default_nettype wire

/* design/sccs_ctrl.sv */
// Controller of the SCCS tag stream extractor: sequences the report line
// pieces for each accepted byte. Uses sccs_pkg.
`default_nettype none

module sccs_ctrl import sccs_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire ctrl_status_t st,
  output ctrl_cmd_t         cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_LEAD, S_HEX, S_GAP, S_FLUSH,
    S_NAME_RD, S_NAME_EM, S_PAD, S_CHR, S_NL
  } state_t;

  state_t     state;
  plan_t      plan;
  logic [3:0] cnt;

  function automatic state_t after_flush(input plan_t p);
    state_t s;
    if (p.chr)     s = S_CHR;
    else if (p.nl) s = S_NL;
    else           s = S_IDLE;
    return s;
  endfunction

  function automatic state_t after_hdr(input plan_t p);
    return p.flush ? S_FLUSH : after_flush(p);
  endfunction

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.sel    = SEL_SPACE;
    cmd.accept = in_valid && in_ready;
    cmd.hex_idx = cnt[2:0];
    unique case (state)
      S_LEAD: begin
        cmd.emit = st.out_free;
        cmd.last = (cnt == 4'd0) && !st.show_offset && !plan.flush && !plan.chr && !plan.nl;
      end
      S_HEX: begin
        cmd.emit = st.out_free;
        cmd.sel  = SEL_HEX;
      end
      S_GAP: begin
        cmd.emit = st.out_free;
        cmd.last = (cnt == 4'd0) && !plan.flush && !plan.chr && !plan.nl;
      end
      S_FLUSH:   cmd.name_start = 1'b1;
      S_NAME_RD: cmd.name_rd = 1'b1;
      S_NAME_EM: begin
        cmd.emit      = st.out_free;
        cmd.sel       = SEL_NAME;
        cmd.name_step = st.out_free;
      end
      S_PAD: begin
        cmd.emit       = st.out_free;
        cmd.last       = (cnt == 4'd1) && !plan.chr && !plan.nl;
        cmd.clear_name = st.out_free && (cnt == 4'd1);
      end
      S_CHR: begin
        cmd.emit = st.out_free;
        cmd.sel  = SEL_REST;
        cmd.last = !plan.nl;
      end
      S_NL: begin
        cmd.emit = st.out_free;
        cmd.sel  = SEL_NEWLINE;
        cmd.last = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      plan  <= '0;
      cnt   <= 4'd0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd.accept) begin
            plan  <= st.plan;
            cnt   <= 4'd1;
            state <= st.plan.hdr ? S_LEAD : after_hdr(st.plan);
          end
        end
        S_LEAD: begin
          if (st.out_free) begin
            if (cnt == 4'd0) begin
              state <= st.show_offset ? S_HEX : after_hdr(plan);
              cnt   <= st.show_offset ? {1'b0, st.ndig_m1} : 4'd1;
            end else begin
              cnt <= cnt - 4'd1;
            end
          end
        end
        S_HEX: begin
          if (st.out_free) begin
            if (cnt == 4'd0) begin
              state <= S_GAP;
              cnt   <= 4'd1;
            end else begin
              cnt <= cnt - 4'd1;
            end
          end
        end
        S_GAP: begin
          if (st.out_free) begin
            if (cnt == 4'd0) state <= after_hdr(plan);
            else cnt <= cnt - 4'd1;
          end
        end
        S_FLUSH: begin
          cnt   <= st.pad_len;
          state <= st.name_nonempty ? S_NAME_RD : S_PAD;
        end
        S_NAME_RD: state <= S_NAME_EM;
        S_NAME_EM: begin
          if (st.out_free) state <= st.name_tail ? S_PAD : S_NAME_RD;
        end
        S_PAD: begin
          if (st.out_free) begin
            if (cnt == 4'd1) state <= after_flush(plan);
            else cnt <= cnt - 4'd1;
          end
        end
        S_CHR: begin
          if (st.out_free) state <= plan.nl ? S_NL : S_IDLE;
        end
        S_NL: begin
          if (st.out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* design/sccs_tag_stream_extractor.sv */
// SCCS tag stream extractor: scans bytes for "@(#)" marks, emits report text.
// After acceptance the controller walks its states, registering each character
// into the output register and waiting while it is full; a name flush passes
// S_FLUSH first, and each name character a registered store read in S_NAME_RD.
// A byte with no output goes straight back to idle; a new byte is taken only in idle.
// Reset (rst, synchronous): clears scan state, offset, config and output.
`default_nettype none
`include "sccs_tag_stream_extractor_assert.svh"

module sccs_tag_stream_extractor import sccs_pkg::*; #(
  parameter int NAME_MAX    = NAME_MAX_DEF,
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire in_item_t               in_data,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output out_item_t                   out_data,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic                   cfg_data
);

  // The name store is not cleared by reset; it is read only below the fill.
  ctrl_cmd_t    cmd;
  ctrl_status_t st;

  // The controller takes a request only when idle, then walks the line
  // pieces: lead spaces, offset digits, gap, name, padding, rest, newline.
  sccs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // The datapath decodes the byte, holds the name store and offset, and
  // owns the output register that parts the two sides.
  sccs_datapath #(
    .NAME_MAX    (NAME_MAX),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Never overwrite a character that is still waiting.
  `SCCS_ASSERT_NOW(a_emit_free, clk, rst, cmd.emit, !out_valid || out_ready)
  // No character is produced in the cycle a request is taken.
  `SCCS_ASSERT_NOW(a_accept_quiet, clk, rst, in_valid && in_ready, !cmd.emit)
  // Once the last character of a request is sent, the block is ready again.
  `SCCS_ASSERT_NEXT(a_last_idle, clk, rst, cmd.emit && cmd.last, in_ready)

endmodule

`default_nettype wire
